@@ sv/scfl_pkg.sv @@
// Package for the spectral centroid, flux and low-band ratio block.
// Holds field widths, register indexes, reset values and sequencer types.
// No dependencies.
package scfl_pkg;

   localparam int MAX_BINS_DEF = 4096;

   localparam int MAG_W      = 16;
   localparam int BINS_W     = 13;
   localparam int BIN_HZ_W   = 20;
   localparam int CUTOFF_W   = 24;
   localparam int CENTROID_W = 24;
   localparam int FLUX_W     = 16;
   localparam int RATIO_W    = 16;
   localparam int SUM_W      = 28;
   localparam int WSUM_W     = 40;
   localparam int MUL_W      = 20;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int NUM_W      = 64;
   localparam int DCNT_W     = 6;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 56;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BINS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_HZ    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF_HZ = 2'd2;

   localparam logic [BINS_W-1:0]   NUM_BINS_RST  = 13'd512;
   localparam logic [BIN_HZ_W-1:0] BIN_HZ_RST    = 20'd5513;
   localparam logic [CUTOFF_W-1:0] CUTOFF_HZ_RST = 24'd64000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_WT,
      ST_MUL_LOW,
      ST_ACC,
      ST_CEN_LO,
      ST_CEN_HI,
      ST_CEN_SUM,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_DIV_STORE,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_CENT,
      PH_RATIO,
      PH_FLUX
   } phase_type;

endpackage

@@ sv/spectral_centroid_flux_lowband.sv @@
// Top level of the spectral centroid, mean positive flux and low-band ratio block.
// Uses scfl_pkg for widths, register indexes and sequencer types.
// One shared 20x20 multiplier and one radix-2 divider run under a small sequencer.

// Each bin is taken in the idle state, then makes two passes through the shared
// 20x20 multiplier (bin index times magnitude, bin index times bin spacing) and
// one accumulate step; req_tready is high only in the idle state, so the next bin
// is not taken until the previous one is through. After the last bin of a frame, two
// multiplier passes and an add build the centroid numerator, the one-bit-per-cycle
// divider runs 64 steps for each of centroid, low-band ratio and flux, each with a
// load and a store step around it, and the output state loads the output register.
// A frame with zero total magnitude skips the centroid and ratio divisions. The result
// sits in an output register, so the next frame's first bin is taken while it waits;
// the block stalls only if a second result is ready before the first is taken.
// Configuration writes are taken at any time and act at once.
module spectral_centroid_flux_lowband #(
   parameter int MAX_BINS = scfl_pkg::MAX_BINS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: mag [15:0], prev_mag [31:16]
   input  logic [scfl_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: prev_valid [0]
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // rsp_tdata: centroid_hz [23:0], flux [39:24], low_ratio [55:40]
   output logic [scfl_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [scfl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [scfl_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Configuration registers
   logic [scfl_pkg::BINS_W-1:0]     num_bins_ff,  num_bins_in;
   logic [scfl_pkg::BIN_HZ_W-1:0]   bin_hz_ff,    bin_hz_in;
   logic [scfl_pkg::CUTOFF_W-1:0]   cutoff_hz_ff, cutoff_hz_in;

   // Sequencer
   scfl_pkg::state_type             state_ff, state_in;
   scfl_pkg::phase_type             phase_ff, phase_in;

   // Running sums
   logic [scfl_pkg::BINS_W-1:0]     bin_index_ff, bin_index_in;
   logic [scfl_pkg::SUM_W-1:0]      sum_mag_ff,   sum_mag_in;
   logic [scfl_pkg::WSUM_W-1:0]     sum_wt_ff,    sum_wt_in;
   logic [scfl_pkg::SUM_W-1:0]      sum_low_ff,   sum_low_in;
   logic [scfl_pkg::SUM_W-1:0]      sum_flux_ff,  sum_flux_in;

   // Captured bin
   logic [scfl_pkg::MAG_W-1:0]      mag_ff,  mag_in;
   logic [scfl_pkg::MAG_W-1:0]      prev_ff, prev_in;
   logic                            pv_ff,   pv_in;

   // Shared multiplier and divider
   logic [scfl_pkg::MUL_W-1:0]      mul_a, mul_b;
   logic [scfl_pkg::PROD_W-1:0]     mul_p;
   logic [scfl_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic [scfl_pkg::NUM_W-1:0]      div_num_ff, div_num_in;
   logic [scfl_pkg::SUM_W-1:0]      div_rem_ff, div_rem_in;
   logic [scfl_pkg::SUM_W-1:0]      div_den_ff, div_den_in;
   logic [scfl_pkg::DCNT_W-1:0]     div_cnt_ff, div_cnt_in;

   // Results
   logic [scfl_pkg::CENTROID_W-1:0] cent_ff,  cent_in;
   logic [scfl_pkg::RATIO_W-1:0]    ratio_ff, ratio_in;
   logic                            rsp_tvalid_ff, rsp_tvalid_in;
   logic [scfl_pkg::RSP_DATA_W-1:0] rsp_data_ff,   rsp_data_in;

   // Combinational helpers
   logic [scfl_pkg::BINS_W-1:0]     frame_len;
   logic                            last_bin;
   logic                            load_rsp;
   logic [scfl_pkg::SUM_W:0]        sum_mag_add, sum_low_add, sum_flux_add;
   logic [scfl_pkg::WSUM_W:0]       sum_wt_add;
   logic [scfl_pkg::SUM_W:0]        div_trial;
   logic [scfl_pkg::SUM_W:0]        div_diff;
   logic                            div_bit;
   logic [scfl_pkg::FLUX_W-1:0]     flux_sat;

   // A bin count of zero means one; counts above MAX_BINS are clamped.
   always_comb begin
      if (num_bins_ff == '0) begin
         frame_len = scfl_pkg::BINS_W'(1);
      end else if (32'(num_bins_ff) > 32'(MAX_BINS)) begin
         frame_len = scfl_pkg::BINS_W'(MAX_BINS);
      end else begin
         frame_len = num_bins_ff;
      end
   end

   assign last_bin = ({1'b0, bin_index_ff} + 14'd1) >= {1'b0, frame_len};
   assign load_rsp = !rsp_tvalid_ff || rsp_tready;
   assign mul_p    = mul_a * mul_b;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scfl_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = scfl_pkg::ST_MUL_WT;
            end
         end
         scfl_pkg::ST_MUL_WT:  state_in = scfl_pkg::ST_MUL_LOW;
         scfl_pkg::ST_MUL_LOW: state_in = scfl_pkg::ST_ACC;
         scfl_pkg::ST_ACC: begin
            state_in = last_bin ? scfl_pkg::ST_CEN_LO : scfl_pkg::ST_IDLE;
         end
         scfl_pkg::ST_CEN_LO: begin
            state_in = (sum_mag_ff == '0) ? scfl_pkg::ST_DIV_LOAD : scfl_pkg::ST_CEN_HI;
         end
         scfl_pkg::ST_CEN_HI:   state_in = scfl_pkg::ST_CEN_SUM;
         scfl_pkg::ST_CEN_SUM:  state_in = scfl_pkg::ST_DIV_LOAD;
         scfl_pkg::ST_DIV_LOAD: state_in = scfl_pkg::ST_DIV_RUN;
         scfl_pkg::ST_DIV_RUN: begin
            if (div_cnt_ff == '1) begin
               state_in = scfl_pkg::ST_DIV_STORE;
            end
         end
         scfl_pkg::ST_DIV_STORE: begin
            state_in = (phase_ff == scfl_pkg::PH_FLUX) ? scfl_pkg::ST_OUT
                                                       : scfl_pkg::ST_DIV_LOAD;
         end
         scfl_pkg::ST_OUT: begin
            if (load_rsp) begin
               state_in = scfl_pkg::ST_IDLE;
            end
         end
         default: state_in = scfl_pkg::ST_IDLE;
      endcase
   end

   // Control outputs: handshake and multiplier operand selection
   always_comb begin
      req_tready = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      case (state_ff)
         scfl_pkg::ST_IDLE: req_tready = 1'b1;
         scfl_pkg::ST_MUL_WT: begin
            mul_a = scfl_pkg::MUL_W'(bin_index_ff);
            mul_b = scfl_pkg::MUL_W'(mag_ff);
         end
         scfl_pkg::ST_MUL_LOW: begin
            mul_a = scfl_pkg::MUL_W'(bin_index_ff);
            mul_b = bin_hz_ff;
         end
         scfl_pkg::ST_CEN_LO: begin
            mul_a = bin_hz_ff;
            mul_b = sum_wt_ff[scfl_pkg::MUL_W-1:0];
         end
         scfl_pkg::ST_CEN_HI: begin
            mul_a = bin_hz_ff;
            mul_b = sum_wt_ff[scfl_pkg::WSUM_W-1:scfl_pkg::MUL_W];
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Saturating adders; every sum saturates at all ones.
   assign sum_mag_add  = {1'b0, sum_mag_ff} + (scfl_pkg::SUM_W+1)'(mag_ff);
   assign sum_low_add  = {1'b0, sum_low_ff} + (scfl_pkg::SUM_W+1)'(mag_ff);
   assign sum_flux_add = {1'b0, sum_flux_ff} + (scfl_pkg::SUM_W+1)'(mag_ff - prev_ff);
   assign sum_wt_add   = {1'b0, sum_wt_ff} + (scfl_pkg::WSUM_W+1)'(prod_ff[28:0]);

   // One restoring division step
   assign div_trial = {div_rem_ff, div_num_ff[scfl_pkg::NUM_W-1]};
   assign div_diff  = div_trial - {1'b0, div_den_ff};
   assign div_bit   = div_trial >= {1'b0, div_den_ff};

   assign flux_sat = (div_num_ff[scfl_pkg::NUM_W-1:scfl_pkg::FLUX_W] != '0)
                     ? '1 : div_num_ff[scfl_pkg::FLUX_W-1:0];

   // Datapath next values
   always_comb begin
      num_bins_in   = num_bins_ff;
      bin_hz_in     = bin_hz_ff;
      cutoff_hz_in  = cutoff_hz_ff;
      phase_in      = phase_ff;
      bin_index_in  = bin_index_ff;
      sum_mag_in    = sum_mag_ff;
      sum_wt_in     = sum_wt_ff;
      sum_low_in    = sum_low_ff;
      sum_flux_in   = sum_flux_ff;
      mag_in        = mag_ff;
      prev_in       = prev_ff;
      pv_in         = pv_ff;
      prod_in       = prod_ff;
      div_num_in    = div_num_ff;
      div_rem_in    = div_rem_ff;
      div_den_in    = div_den_ff;
      div_cnt_in    = div_cnt_ff;
      cent_in       = cent_ff;
      ratio_in      = ratio_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;

      if (csr_we) begin
         case (csr_index)
            scfl_pkg::CSR_NUM_BINS:  num_bins_in  = csr_wdata[scfl_pkg::BINS_W-1:0];
            scfl_pkg::CSR_BIN_HZ:    bin_hz_in    = csr_wdata[scfl_pkg::BIN_HZ_W-1:0];
            scfl_pkg::CSR_CUTOFF_HZ: cutoff_hz_in = csr_wdata;
            default: num_bins_in = num_bins_ff;
         endcase
      end

      case (state_ff)
         scfl_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               mag_in  = req_tdata[15:0];
               prev_in = req_tdata[31:16];
               pv_in   = req_tuser;
            end
         end
         scfl_pkg::ST_MUL_WT: begin
            prod_in = mul_p;
         end
         scfl_pkg::ST_MUL_LOW: begin
            sum_wt_in = sum_wt_add[scfl_pkg::WSUM_W] ? '1 : sum_wt_add[scfl_pkg::WSUM_W-1:0];
            prod_in   = mul_p;
         end
         scfl_pkg::ST_ACC: begin
            sum_mag_in = sum_mag_add[scfl_pkg::SUM_W] ? '1 : sum_mag_add[scfl_pkg::SUM_W-1:0];
            if (prod_ff[32:0] < 33'(cutoff_hz_ff)) begin
               sum_low_in = sum_low_add[scfl_pkg::SUM_W] ? '1
                                                         : sum_low_add[scfl_pkg::SUM_W-1:0];
            end
            if (pv_ff && (mag_ff > prev_ff)) begin
               sum_flux_in = sum_flux_add[scfl_pkg::SUM_W] ? '1
                                                           : sum_flux_add[scfl_pkg::SUM_W-1:0];
            end
            if (!last_bin) begin
               bin_index_in = bin_index_ff + 1'b1;
            end
         end
         scfl_pkg::ST_CEN_LO: begin
            prod_in = mul_p;
            if (sum_mag_ff == '0) begin
               // No energy: centroid and ratio are zero, only flux is divided.
               cent_in  = '0;
               ratio_in = '0;
               phase_in = scfl_pkg::PH_FLUX;
            end
         end
         scfl_pkg::ST_CEN_HI: begin
            div_num_in = scfl_pkg::NUM_W'(prod_ff);
            prod_in    = mul_p;
         end
         scfl_pkg::ST_CEN_SUM: begin
            div_num_in = div_num_ff + {4'd0, prod_ff, 20'd0}
                         + scfl_pkg::NUM_W'(sum_mag_ff[scfl_pkg::SUM_W-1:1]);
            phase_in   = scfl_pkg::PH_CENT;
         end
         scfl_pkg::ST_DIV_LOAD: begin
            div_rem_in = '0;
            div_cnt_in = '0;
            case (phase_ff)
               scfl_pkg::PH_CENT: begin
                  div_den_in = sum_mag_ff;
               end
               scfl_pkg::PH_RATIO: begin
                  div_den_in = sum_mag_ff;
                  div_num_in = {20'd0, sum_low_ff, 16'd0}
                               + scfl_pkg::NUM_W'(sum_mag_ff[scfl_pkg::SUM_W-1:1]);
               end
               default: begin
                  div_den_in = scfl_pkg::SUM_W'(frame_len);
                  div_num_in = scfl_pkg::NUM_W'(sum_flux_ff)
                               + scfl_pkg::NUM_W'(frame_len[scfl_pkg::BINS_W-1:1]);
               end
            endcase
         end
         scfl_pkg::ST_DIV_RUN: begin
            div_rem_in = div_bit ? div_diff[scfl_pkg::SUM_W-1:0]
                                 : div_trial[scfl_pkg::SUM_W-1:0];
            div_num_in = {div_num_ff[scfl_pkg::NUM_W-2:0], div_bit};
            div_cnt_in = div_cnt_ff + 1'b1;
         end
         scfl_pkg::ST_DIV_STORE: begin
            case (phase_ff)
               scfl_pkg::PH_CENT: begin
                  cent_in  = (div_num_ff[scfl_pkg::NUM_W-1:scfl_pkg::CENTROID_W] != '0)
                             ? '1 : div_num_ff[scfl_pkg::CENTROID_W-1:0];
                  phase_in = scfl_pkg::PH_RATIO;
               end
               scfl_pkg::PH_RATIO: begin
                  ratio_in = (div_num_ff[scfl_pkg::NUM_W-1:scfl_pkg::RATIO_W] != '0)
                             ? '1 : div_num_ff[scfl_pkg::RATIO_W-1:0];
                  phase_in = scfl_pkg::PH_FLUX;
               end
               default: begin
                  // Flux quotient stays in div_num_ff until the result is loaded.
                  phase_in = scfl_pkg::PH_FLUX;
               end
            endcase
         end
         scfl_pkg::ST_OUT: begin
            if (load_rsp) begin
               rsp_data_in   = {ratio_ff, flux_sat, cent_ff};
               rsp_tvalid_in = 1'b1;
               bin_index_in  = '0;
               sum_mag_in    = '0;
               sum_wt_in     = '0;
               sum_low_in    = '0;
               sum_flux_in   = '0;
            end
         end
         default: begin
            prod_in = prod_ff;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= scfl_pkg::ST_IDLE;
         phase_ff      <= scfl_pkg::PH_CENT;
         num_bins_ff   <= scfl_pkg::NUM_BINS_RST;
         bin_hz_ff     <= scfl_pkg::BIN_HZ_RST;
         cutoff_hz_ff  <= scfl_pkg::CUTOFF_HZ_RST;
         bin_index_ff  <= '0;
         sum_mag_ff    <= '0;
         sum_wt_ff     <= '0;
         sum_low_ff    <= '0;
         sum_flux_ff   <= '0;
         div_cnt_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         num_bins_ff   <= num_bins_in;
         bin_hz_ff     <= bin_hz_in;
         cutoff_hz_ff  <= cutoff_hz_in;
         bin_index_ff  <= bin_index_in;
         sum_mag_ff    <= sum_mag_in;
         sum_wt_ff     <= sum_wt_in;
         sum_low_ff    <= sum_low_in;
         sum_flux_ff   <= sum_flux_in;
         div_cnt_ff    <= div_cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      prev_ff     <= prev_in;
      pv_ff       <= pv_in;
      prod_ff     <= prod_in;
      div_num_ff  <= div_num_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      cent_ff     <= cent_in;
      ratio_ff    <= ratio_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The low-band sum only ever adds magnitudes that also go into the total.
   a_low_le_total: assert property (@(posedge clock) disable iff (reset)
      sum_low_ff <= sum_mag_ff)
      else $error("low-band sum exceeds total magnitude sum");

   // The partial remainder always stays below a nonzero divisor.
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scfl_pkg::ST_DIV_RUN) |-> (div_den_ff != '0) && (div_rem_ff < div_den_ff))
      else $error("divider remainder out of range");

   // The low-band share can never exceed one.
   a_ratio_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scfl_pkg::ST_DIV_STORE) && (phase_ff == scfl_pkg::PH_RATIO)
      |-> (div_num_ff[scfl_pkg::NUM_W-1:17] == '0))
      else $error("ratio quotient above one");

   // Loading a result starts the next frame from cleared sums.
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scfl_pkg::ST_OUT) && load_rsp
      |=> rsp_tvalid_ff && (bin_index_ff == '0) && (sum_mag_ff == '0)
          && (sum_flux_ff == '0) && (state_ff == scfl_pkg::ST_IDLE))
      else $error("result load did not restart the frame");

endmodule
